FILE: design/cpu8ae_pkg.sv
// ----------------------------------------------------------------------------
// cpu8ae_pkg
// Types and codes shared by the arithmetic execution unit of an 8-bit CPU.
// ----------------------------------------------------------------------------
package cpu8ae_pkg;

  localparam int NUM_REGS = 7;

  // operation codes
  localparam logic [3:0] MODE_ADD = 4'd0;
  localparam logic [3:0] MODE_SUB = 4'd1;
  localparam logic [3:0] MODE_ADI = 4'd2;
  localparam logic [3:0] MODE_SUI = 4'd3;
  localparam logic [3:0] MODE_INR = 4'd4;
  localparam logic [3:0] MODE_DCR = 4'd5;
  localparam logic [3:0] MODE_DAD = 4'd6;
  localparam logic [3:0] MODE_INX = 4'd7;
  localparam logic [3:0] MODE_DCX = 4'd8;

  // register selector codes
  localparam logic [2:0] REG_A = 3'd0;
  localparam logic [2:0] REG_B = 3'd1;
  localparam logic [2:0] REG_C = 3'd2;
  localparam logic [2:0] REG_D = 3'd3;
  localparam logic [2:0] REG_E = 3'd4;
  localparam logic [2:0] REG_H = 3'd5;
  localparam logic [2:0] REG_L = 3'd6;
  localparam logic [2:0] REG_M = 3'd7;

  // register pair codes
  localparam logic [1:0] PAIR_BC  = 2'd0;
  localparam logic [1:0] PAIR_DE  = 2'd1;
  localparam logic [1:0] PAIR_HL  = 2'd2;
  localparam logic [1:0] PAIR_BAD = 2'd3;

  // flag bit positions
  localparam int FLAG_S  = 7;
  localparam int FLAG_Z  = 6;
  localparam int FLAG_AC = 4;
  localparam int FLAG_P  = 2;
  localparam int FLAG_CY = 0;

  typedef struct packed {
    logic [3:0] mode;
    logic [2:0] reg_sel;
    logic [1:0] pair_sel;
    logic [7:0] immediate;
    logic [7:0] mem_data;
  } item_t;

  typedef struct packed {
    logic [NUM_REGS-1:0][7:0] regs;
    logic [7:0]               flags;
  } cpu_state_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  flag_byte;
    logic [15:0] hl_addr;
    logic        mem_we;
    logic [7:0]  mem_wdata;
    logic        bad_op;
  } result_t;

endpackage

FILE: design/cpu8ae_state.sv
// ----------------------------------------------------------------------------
// cpu8ae_state
// Register file (A,B,C,D,E,H,L) and flag byte, loaded once per transaction.
// ----------------------------------------------------------------------------
module cpu8ae_state (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  cpu8ae_pkg::cpu_state_t state_next,
  output cpu8ae_pkg::cpu_state_t state
);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (load) begin
      state <= state_next;
    end
  end

endmodule

FILE: design/cpu8ae_alu.sv
// ----------------------------------------------------------------------------
// cpu8ae_alu
// Executes one arithmetic-group instruction on the current CPU state.
// ----------------------------------------------------------------------------
module cpu8ae_alu (
  input  cpu8ae_pkg::item_t      item,
  input  cpu8ae_pkg::cpu_state_t state,
  output cpu8ae_pkg::cpu_state_t state_next,
  output cpu8ae_pkg::result_t    result
);

  logic        bad;
  logic        is_sub;
  logic [7:0]  opnd;
  logic [7:0]  op_a;
  logic [7:0]  op_b;
  logic [8:0]  sum9;
  logic        aux;
  logic [7:0]  res8;
  logic [7:0]  szp;
  logic [15:0] pair_val;
  logic [15:0] hl_val;
  logic [16:0] dad_sum;
  logic [15:0] pair_inc;
  logic [2:0]  hi_idx;
  logic [2:0]  lo_idx;

  always_comb begin
    bad = (item.mode > cpu8ae_pkg::MODE_DCX) ||
          ((item.mode >= cpu8ae_pkg::MODE_DAD) && (item.pair_sel == cpu8ae_pkg::PAIR_BAD));

    unique case (item.reg_sel)
      cpu8ae_pkg::REG_A: opnd = state.regs[cpu8ae_pkg::REG_A];
      cpu8ae_pkg::REG_B: opnd = state.regs[cpu8ae_pkg::REG_B];
      cpu8ae_pkg::REG_C: opnd = state.regs[cpu8ae_pkg::REG_C];
      cpu8ae_pkg::REG_D: opnd = state.regs[cpu8ae_pkg::REG_D];
      cpu8ae_pkg::REG_E: opnd = state.regs[cpu8ae_pkg::REG_E];
      cpu8ae_pkg::REG_H: opnd = state.regs[cpu8ae_pkg::REG_H];
      cpu8ae_pkg::REG_L: opnd = state.regs[cpu8ae_pkg::REG_L];
      default:           opnd = item.mem_data;
    endcase

    unique case (item.pair_sel)
      cpu8ae_pkg::PAIR_BC: pair_val = {state.regs[cpu8ae_pkg::REG_B],
                                       state.regs[cpu8ae_pkg::REG_C]};
      cpu8ae_pkg::PAIR_DE: pair_val = {state.regs[cpu8ae_pkg::REG_D],
                                       state.regs[cpu8ae_pkg::REG_E]};
      cpu8ae_pkg::PAIR_HL: pair_val = {state.regs[cpu8ae_pkg::REG_H],
                                       state.regs[cpu8ae_pkg::REG_L]};
      default:             pair_val = '0;
    endcase

    hi_idx = {item.pair_sel, 1'b1};
    lo_idx = hi_idx + 3'd1;
    hl_val = {state.regs[cpu8ae_pkg::REG_H], state.regs[cpu8ae_pkg::REG_L]};

    // shared 8-bit adder
    is_sub = (item.mode == cpu8ae_pkg::MODE_SUB) || (item.mode == cpu8ae_pkg::MODE_SUI) ||
             (item.mode == cpu8ae_pkg::MODE_DCR);
    priority if ((item.mode == cpu8ae_pkg::MODE_INR) || (item.mode == cpu8ae_pkg::MODE_DCR)) begin
      op_a = opnd;
      op_b = 8'd1;
    end else if ((item.mode == cpu8ae_pkg::MODE_ADI) ||
                 (item.mode == cpu8ae_pkg::MODE_SUI)) begin
      op_a = state.regs[cpu8ae_pkg::REG_A];
      op_b = item.immediate;
    end else begin
      op_a = state.regs[cpu8ae_pkg::REG_A];
      op_b = opnd;
    end

    if (is_sub) begin
      sum9 = {1'b0, op_a} - {1'b0, op_b};
      aux  = op_a[3:0] < op_b[3:0];
    end else begin
      sum9 = {1'b0, op_a} + {1'b0, op_b};
      aux  = ({1'b0, op_a[3:0]} + {1'b0, op_b[3:0]}) > 5'd15;
    end
    res8 = sum9[7:0];

    szp                     = '0;
    szp[cpu8ae_pkg::FLAG_S]  = res8[7];
    szp[cpu8ae_pkg::FLAG_Z]  = (res8 == 8'd0);
    szp[cpu8ae_pkg::FLAG_AC] = aux;
    szp[cpu8ae_pkg::FLAG_P]  = ~^res8;

    dad_sum  = {1'b0, hl_val} + {1'b0, pair_val};
    pair_inc = (item.mode == cpu8ae_pkg::MODE_INX) ? pair_val + 16'd1 : pair_val - 16'd1;

    state_next       = state;
    result.mem_we    = 1'b0;
    result.mem_wdata = '0;
    result.bad_op    = bad;

    if (!bad) begin
      unique case (item.mode)
        cpu8ae_pkg::MODE_ADD, cpu8ae_pkg::MODE_SUB,
        cpu8ae_pkg::MODE_ADI, cpu8ae_pkg::MODE_SUI: begin
          state_next.regs[cpu8ae_pkg::REG_A] = res8;
          state_next.flags                   = szp;
          state_next.flags[cpu8ae_pkg::FLAG_CY] = sum9[8];
        end
        cpu8ae_pkg::MODE_INR, cpu8ae_pkg::MODE_DCR: begin
          state_next.flags                      = szp;
          state_next.flags[cpu8ae_pkg::FLAG_CY] = state.flags[cpu8ae_pkg::FLAG_CY];
          if (item.reg_sel == cpu8ae_pkg::REG_M) begin
            result.mem_we    = 1'b1;
            result.mem_wdata = res8;
          end else begin
            state_next.regs[item.reg_sel] = res8;
          end
        end
        cpu8ae_pkg::MODE_DAD: begin
          state_next.regs[cpu8ae_pkg::REG_H]    = dad_sum[15:8];
          state_next.regs[cpu8ae_pkg::REG_L]    = dad_sum[7:0];
          state_next.flags[cpu8ae_pkg::FLAG_CY] = dad_sum[16];
        end
        cpu8ae_pkg::MODE_INX, cpu8ae_pkg::MODE_DCX: begin
          state_next.regs[hi_idx] = pair_inc[15:8];
          state_next.regs[lo_idx] = pair_inc[7:0];
        end
        default: begin
          state_next = state;
        end
      endcase
    end

    result.acc       = state_next.regs[cpu8ae_pkg::REG_A];
    result.flag_byte = state_next.flags;
    result.hl_addr   = {state_next.regs[cpu8ae_pkg::REG_H], state_next.regs[cpu8ae_pkg::REG_L]};
  end

endmodule

FILE: design/cpu8_arith_exec_unit.sv
// ----------------------------------------------------------------------------
// cpu8_arith_exec_unit
// Arithmetic-group execution unit of an 8-bit CPU: ADD, SUB, ADI, SUI, INR,
// DCR, DAD, INX and DCX on seven 8-bit registers and a flag byte.
//
//   channel  dir  handshake                 payload
//   s_axis   in   s_tvalid / s_tready       s_tdata[31:0]  instruction
//   m_axis   out  m_tvalid / m_tready       m_tdata[47:0]  execution result
//
// An instruction passes one input register; the execute logic then updates
// the register file and loads the result register in the same cycle. One
// instruction per cycle while the output is not stalled; the register-file
// update loop sets that rate. Reset clears all CPU registers and flags. A
// stalled output holds the result and backs up into the input stage.
// ----------------------------------------------------------------------------
module cpu8_arith_exec_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mode[3:0], reg_sel[6:4], pair_sel[8:7], immediate[16:9], mem_data[24:17]
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // acc[7:0], flag_byte[15:8], hl_addr[31:16], mem_we[32], mem_wdata[40:33],
  // bad_op[41]
  output logic [47:0] m_tdata
);

  cpu8ae_pkg::item_t      item_in;
  cpu8ae_pkg::item_t      item_q;
  logic                   item_valid;
  logic                   exec_fire;
  logic                   out_ready;
  cpu8ae_pkg::cpu_state_t state;
  cpu8ae_pkg::cpu_state_t state_next;
  cpu8ae_pkg::result_t    exec_res;
  cpu8ae_pkg::result_t    res_q;
  logic                   res_valid;

  assign item_in.mode      = s_tdata[3:0];
  assign item_in.reg_sel   = s_tdata[6:4];
  assign item_in.pair_sel  = s_tdata[8:7];
  assign item_in.immediate = s_tdata[16:9];
  assign item_in.mem_data  = s_tdata[24:17];

  assign out_ready = !res_valid || m_tready;
  assign exec_fire = item_valid && out_ready;
  assign s_tready  = !item_valid || exec_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item_q <= item_in;
    end
  end

  cpu8ae_alu u_alu (
    .item       (item_q),
    .state      (state),
    .state_next (state_next),
    .result     (exec_res)
  );

  cpu8ae_state u_state (
    .clk        (clk),
    .rst        (rst),
    .load       (exec_fire),
    .state_next (state_next),
    .state      (state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      res_q <= exec_res;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {6'b0, res_q.bad_op, res_q.mem_wdata, res_q.mem_we,
                     res_q.hl_addr, res_q.flag_byte, res_q.acc};

`ifndef ASSERT_OFF
  a_bad_keeps_state: assert property (@(posedge clk) disable iff (rst)
    exec_fire && exec_res.bad_op |=> $stable(state))
    else $error("invalid instruction changed CPU state");

  a_mem_write_source: assert property (@(posedge clk) disable iff (rst)
    exec_fire && exec_res.mem_we |-> (item_q.reg_sel == cpu8ae_pkg::REG_M) &&
      ((item_q.mode == cpu8ae_pkg::MODE_INR) || (item_q.mode == cpu8ae_pkg::MODE_DCR)))
    else $error("memory write without INR/DCR on memory");

  a_flag_zero_bits: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_q.flag_byte[5] == 1'b0) && (res_q.flag_byte[3] == 1'b0) &&
      (res_q.flag_byte[1] == 1'b0))
    else $error("reserved flag bits set");

  a_pair_ops_keep_flags: assert property (@(posedge clk) disable iff (rst)
    exec_fire && ((item_q.mode == cpu8ae_pkg::MODE_INX) ||
      (item_q.mode == cpu8ae_pkg::MODE_DCX)) |=> $stable(state.flags))
    else $error("INX/DCX changed flags");

  a_no_exec_when_blocked: assert property (@(posedge clk) disable iff (rst)
    res_valid && !m_tready |=> $stable(state))
    else $error("state changed while output stalled");
`endif

endmodule
